@@ rtl/core/amc_pkg.sv @@
// Shared types and codes of the multi-pattern string matcher.
`default_nettype none
package amc_pkg;

   // Request codes carried in the req_type field.
   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_BUILD  = 2'd1,
      REQ_MATCH  = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_code_type;

   // Status codes of a result beat.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_BUILT = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] ch;
      logic        first;
      logic        last;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic       hit;
      logic       found;
   } rsp_payload_type;

   // Per-field write enables of the node store.
   typedef struct packed {
      logic chr_we;
      logic par_we;
      logic fail_we;
      logic mark_we;
   } mem_we_type;

   // Finished result handed from the sequencer to the output register.
   typedef struct packed {
      logic       valid;
      logic [1:0] status;
      logic       hit;
      logic       found;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FAIL_RD,
      ST_FAIL_WT,
      ST_RET,
      ST_M_END,
      ST_B_RD,
      ST_B_CK,
      ST_B_END,
      ST_B_NEXT_U,
      ST_B_QWT,
      ST_B_UWT,
      ST_DONE
   } seq_state_type;

endpackage
`default_nettype wire

@@ rtl/core/amc_stream_if.sv @@
// Valid/ready channel carrying one payload beat.
`default_nettype none
interface amc_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/amc_node_mem.sv @@
// Node store of the trie: edge char, parent, failure link and end mark.
`default_nettype none
module amc_node_mem import amc_pkg::*; #(
   parameter int MAX_NODES = 256,
   parameter int CHAR_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic [$clog2(MAX_NODES)-1:0]   rd_addr,
   output logic [((CHAR_BITS < 16) ? CHAR_BITS : 16)-1:0] rd_chr,
   output logic [$clog2(MAX_NODES)-1:0]        rd_par,
   output logic [$clog2(MAX_NODES)-1:0]        rd_fail,
   output logic                                rd_mark,
   input  wire logic [$clog2(MAX_NODES)-1:0]   wr_addr,
   input  wire logic [((CHAR_BITS < 16) ? CHAR_BITS : 16)-1:0] wr_chr,
   input  wire logic [$clog2(MAX_NODES)-1:0]   wr_par,
   input  wire logic [$clog2(MAX_NODES)-1:0]   wr_fail,
   input  wire logic                           wr_mark,
   input  wire mem_we_type                     we
);
   localparam int AW = $clog2(MAX_NODES);
   localparam int EW = (CHAR_BITS < 16) ? CHAR_BITS : 16;

   logic [EW-1:0] chr_mem  [MAX_NODES];
   logic [AW-1:0] par_mem  [MAX_NODES];
   logic [AW-1:0] fail_mem [MAX_NODES];
   logic          mark_mem [MAX_NODES];

   logic [EW-1:0] chr_ff;
   logic [AW-1:0] par_ff;
   logic [AW-1:0] fail_ff;
   logic          mark_ff;
   logic          root_ff;

   // One write port with a separate enable for each field.
   always_ff @(posedge clock) begin
      if (we.chr_we) chr_mem[wr_addr] <= wr_chr;
      if (we.par_we) par_mem[wr_addr] <= wr_par;
      if (we.fail_we) fail_mem[wr_addr] <= wr_fail;
      if (we.mark_we) mark_mem[wr_addr] <= wr_mark;
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      chr_ff  <= chr_mem[rd_addr];
      par_ff  <= par_mem[rd_addr];
      fail_ff <= fail_mem[rd_addr];
      mark_ff <= mark_mem[rd_addr];
      root_ff <= (rd_addr == '0);
   end

   // The root never gets written: its link is itself and it never ends a pattern.
   assign rd_chr  = chr_ff;
   assign rd_par  = par_ff;
   assign rd_fail = root_ff ? '0 : fail_ff;
   assign rd_mark = root_ff ? 1'b0 : mark_ff;
endmodule
`default_nettype wire

@@ rtl/core/amc_seq.sv @@
// Sequencer: child search, failure chasing, build walk and result formation.
`default_nettype none
module amc_seq import amc_pkg::*; #(
   parameter int MAX_NODES = 256,
   parameter int CHAR_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire req_payload_type                req,
   output logic                                idle,
   input  wire logic                           res_free,
   output result_type                          res,
   output logic [$clog2(MAX_NODES)-1:0]        rd_addr,
   input  wire logic [((CHAR_BITS < 16) ? CHAR_BITS : 16)-1:0] rd_chr,
   input  wire logic [$clog2(MAX_NODES)-1:0]   rd_par,
   input  wire logic [$clog2(MAX_NODES)-1:0]   rd_fail,
   input  wire logic                           rd_mark,
   output logic [$clog2(MAX_NODES)-1:0]        wr_addr,
   output logic [((CHAR_BITS < 16) ? CHAR_BITS : 16)-1:0] wr_chr,
   output logic [$clog2(MAX_NODES)-1:0]        wr_par,
   output logic [$clog2(MAX_NODES)-1:0]        wr_fail,
   output logic                                wr_mark,
   output mem_we_type                          we
);
   localparam int AW = $clog2(MAX_NODES);
   localparam int CW = AW + 1;
   localparam int EW = (CHAR_BITS < 16) ? CHAR_BITS : 16;
   localparam logic [CW-1:0] NODE_LIMIT = CW'(MAX_NODES);
   localparam logic [CW-1:0] ONE = CW'(1);

   seq_state_type state_ff, state_in;
   req_code_type  op_ff, op_in;
   logic [EW-1:0] c_ff, c_in;
   logic          last_ff, last_in;
   logic [AW-1:0] s_ff, s_in;
   logic [AW-1:0] g_ff, g_in;
   logic          nofollow_ff, nofollow_in;
   logic [CW-1:0] sc_idx_ff, sc_idx_in;
   logic          sc_pend_ff, sc_pend_in;
   logic [AW-1:0] sc_cmp_ff, sc_cmp_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [AW-1:0] node_ff, node_in;
   logic          found_ff, found_in;
   logic          built_ff, built_in;
   logic          blocked_ff, blocked_in;
   logic [AW-1:0] u_ff, u_in;
   logic [AW-1:0] failu_ff, failu_in;
   logic [CW-1:0] bi_ff, bi_in;
   logic [AW-1:0] fi_ff, fi_in;
   logic [CW-1:0] head_ff, head_in;
   logic [CW-1:0] tail_ff, tail_in;
   logic [1:0]    rstat_ff, rstat_in;
   logic          rhit_ff, rhit_in;
   logic          rfound_ff, rfound_in;
   logic          sc_hit;
   logic          enq;
   logic [AW-1:0] fi_calc;

   // Work queue of the breadth-first build.
   logic [AW-1:0] qmem [MAX_NODES];
   logic [AW-1:0] q_rd_ff;

   always_ff @(posedge clock) begin
      if (enq) qmem[tail_ff[AW-1:0]] <= bi_ff[AW-1:0];
      q_rd_ff <= qmem[head_ff[AW-1:0]];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= ONE;
         cursor_ff  <= '0;
         node_ff    <= '0;
         found_ff   <= 1'b0;
         built_ff   <= 1'b0;
         blocked_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cursor_ff  <= cursor_in;
         node_ff    <= node_in;
         found_ff   <= found_in;
         built_ff   <= built_in;
         blocked_ff <= blocked_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      c_ff        <= c_in;
      last_ff     <= last_in;
      s_ff        <= s_in;
      g_ff        <= g_in;
      nofollow_ff <= nofollow_in;
      sc_idx_ff   <= sc_idx_in;
      sc_pend_ff  <= sc_pend_in;
      sc_cmp_ff   <= sc_cmp_in;
      u_ff        <= u_in;
      failu_ff    <= failu_in;
      bi_ff       <= bi_in;
      fi_ff       <= fi_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      rstat_ff    <= rstat_in;
      rhit_ff     <= rhit_in;
      rfound_ff   <= rfound_in;
   end

   assign sc_hit  = sc_pend_ff && (rd_par == s_ff) && (rd_chr == c_ff);
   assign fi_calc = ((g_ff != '0) && (g_ff != bi_ff[AW-1:0])) ? g_ff : '0;
   assign idle    = (state_ff == ST_IDLE);

   // Next state and datapath control.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      c_in        = c_ff;
      last_in     = last_ff;
      s_in        = s_ff;
      g_in        = g_ff;
      nofollow_in = nofollow_ff;
      sc_idx_in   = sc_idx_ff;
      sc_pend_in  = sc_pend_ff;
      sc_cmp_in   = sc_cmp_ff;
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      node_in     = node_ff;
      found_in    = found_ff;
      built_in    = built_ff;
      blocked_in  = blocked_ff;
      u_in        = u_ff;
      failu_in    = failu_ff;
      bi_in       = bi_ff;
      fi_in       = fi_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      rstat_in    = rstat_ff;
      rhit_in     = rhit_ff;
      rfound_in   = rfound_ff;
      rd_addr     = '0;
      wr_addr     = '0;
      wr_chr      = c_ff;
      wr_par      = cursor_ff;
      wr_fail     = '0;
      wr_mark     = 1'b1;
      we          = '0;
      enq         = 1'b0;
      res         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = req_code_type'(req.req_type);
               c_in       = req.ch[EW-1:0];
               last_in    = req.last;
               sc_idx_in  = ONE;
               sc_pend_in = 1'b0;
               rstat_in   = STAT_OK;
               rhit_in    = 1'b0;
               rfound_in  = 1'b0;
               unique case (req_code_type'(req.req_type))
                  REQ_INSERT: begin
                     built_in = 1'b0;
                     if (req.first) begin
                        cursor_in  = '0;
                        blocked_in = 1'b0;
                     end
                     if (blocked_ff && !req.first) begin
                        rstat_in = STAT_FULL;
                        state_in = ST_DONE;
                     end else begin
                        s_in        = req.first ? '0 : cursor_ff;
                        nofollow_in = 1'b1;
                        state_in    = ST_SCAN;
                     end
                  end
                  REQ_BUILD: begin
                     u_in     = '0;
                     failu_in = '0;
                     bi_in    = ONE;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = ST_B_RD;
                  end
                  REQ_MATCH: begin
                     if (req.first) begin
                        node_in  = '0;
                        found_in = 1'b0;
                     end
                     if (!built_ff) begin
                        rstat_in = STAT_NOT_BUILT;
                        state_in = ST_DONE;
                     end else begin
                        s_in        = req.first ? '0 : node_ff;
                        nofollow_in = 1'b0;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     count_in   = ONE;
                     cursor_in  = '0;
                     node_in    = '0;
                     found_in   = 1'b0;
                     built_in   = 1'b0;
                     blocked_in = 1'b0;
                     state_in   = ST_DONE;
                  end
               endcase
            end
         end

         // Child search: one node read issued per cycle, compared in the cycle after.
         ST_SCAN: begin
            if (sc_hit) begin
               g_in       = sc_cmp_ff;
               sc_pend_in = 1'b0;
               state_in   = ST_RET;
            end else if (sc_idx_ff < count_ff) begin
               rd_addr    = sc_idx_ff[AW-1:0];
               sc_pend_in = 1'b1;
               sc_cmp_in  = sc_idx_ff[AW-1:0];
               sc_idx_in  = sc_idx_ff + ONE;
            end else begin
               sc_pend_in = 1'b0;
               if ((s_ff == '0) || nofollow_ff) begin
                  g_in     = '0;
                  state_in = ST_RET;
               end else begin
                  state_in = ST_FAIL_RD;
               end
            end
         end

         // No child here: step along the failure link and search again.
         ST_FAIL_RD: begin
            rd_addr  = s_ff;
            state_in = ST_FAIL_WT;
         end
         ST_FAIL_WT: begin
            s_in       = rd_fail;
            sc_idx_in  = ONE;
            sc_pend_in = 1'b0;
            state_in   = ST_SCAN;
         end

         // Search finished: finish the request that started it.
         ST_RET: begin
            unique case (op_ff)
               REQ_INSERT: begin
                  state_in = ST_DONE;
                  if (g_ff != '0) begin
                     cursor_in = g_ff;
                     wr_addr   = g_ff;
                     we.mark_we = last_ff;
                  end else if (count_ff < NODE_LIMIT) begin
                     wr_addr   = count_ff[AW-1:0];
                     wr_chr    = c_ff;
                     wr_par    = cursor_ff;
                     wr_fail   = '0;
                     wr_mark   = last_ff;
                     we        = '1;
                     cursor_in = count_ff[AW-1:0];
                     count_in  = count_ff + ONE;
                  end else begin
                     blocked_in = 1'b1;
                     rstat_in   = STAT_FULL;
                  end
               end
               REQ_MATCH: begin
                  rd_addr  = g_ff;
                  state_in = ST_M_END;
               end
               REQ_BUILD: begin
                  fi_in    = fi_calc;
                  rd_addr  = fi_calc;
                  state_in = ST_B_END;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_M_END: begin
            node_in   = g_ff;
            found_in  = found_ff | rd_mark;
            rhit_in   = rd_mark;
            rfound_in = found_ff | rd_mark;
            state_in  = ST_DONE;
         end

         // Build: walk all nodes looking for children of the current node.
         ST_B_RD: begin
            if (bi_ff < count_ff) begin
               rd_addr  = bi_ff[AW-1:0];
               state_in = ST_B_CK;
            end else begin
               state_in = ST_B_NEXT_U;
            end
         end
         ST_B_CK: begin
            if ((rd_par == u_ff) && (bi_ff[AW-1:0] != u_ff)) begin
               if (u_ff == '0) begin
                  wr_addr    = bi_ff[AW-1:0];
                  wr_fail    = '0;
                  we.fail_we = 1'b1;
                  enq        = 1'b1;
                  tail_in    = tail_ff + ONE;
                  bi_in      = bi_ff + ONE;
                  state_in   = ST_B_RD;
               end else begin
                  c_in        = rd_chr;
                  s_in        = failu_ff;
                  nofollow_in = 1'b0;
                  sc_idx_in   = ONE;
                  sc_pend_in  = 1'b0;
                  state_in    = ST_SCAN;
               end
            end else begin
               bi_in    = bi_ff + ONE;
               state_in = ST_B_RD;
            end
         end
         ST_B_END: begin
            wr_addr    = bi_ff[AW-1:0];
            wr_fail    = fi_ff;
            wr_mark    = 1'b1;
            we.fail_we = 1'b1;
            we.mark_we = rd_mark;
            enq        = 1'b1;
            tail_in    = tail_ff + ONE;
            bi_in      = bi_ff + ONE;
            state_in   = ST_B_RD;
         end
         ST_B_NEXT_U: begin
            if (head_ff < tail_ff) begin
               state_in = ST_B_QWT;
            end else begin
               built_in = 1'b1;
               node_in  = '0;
               found_in = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_B_QWT: begin
            u_in     = q_rd_ff;
            head_in  = head_ff + ONE;
            rd_addr  = q_rd_ff;
            state_in = ST_B_UWT;
         end
         ST_B_UWT: begin
            failu_in = rd_fail;
            bi_in    = ONE;
            state_in = ST_B_RD;
         end

         // Hand the result over once the output register is free.
         ST_DONE: begin
            if (res_free) begin
               res.valid  = 1'b1;
               res.status = rstat_ff;
               res.hit    = rhit_ff;
               res.found  = rfound_ff;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/core/multi_pattern_string_matcher.sv @@
// The node search reads one stored node per cycle through the node store's single read port.
// One item is in work at a time; the next is taken once the result is in the output register.
// Synchronous active-high reset empties the trie (root only) and clears the match walk.
`default_nettype none
module multi_pattern_string_matcher import amc_pkg::*; #(
   parameter int MAX_NODES = 256,
   parameter int CHAR_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   amc_stream_if.sink   req_if,
   amc_stream_if.source rsp_if
);
   localparam int AW = $clog2(MAX_NODES);
   localparam int EW = (CHAR_BITS < 16) ? CHAR_BITS : 16;

   logic            idle;
   logic            start;
   logic            res_free;
   result_type      res;
   logic [AW-1:0]   rd_addr;
   logic [EW-1:0]   rd_chr;
   logic [AW-1:0]   rd_par;
   logic [AW-1:0]   rd_fail;
   logic            rd_mark;
   logic [AW-1:0]   wr_addr;
   logic [EW-1:0]   wr_chr;
   logic [AW-1:0]   wr_par;
   logic [AW-1:0]   wr_fail;
   logic            wr_mark;
   mem_we_type      we;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   assign req_if.ready = idle;
   assign start        = req_if.valid && idle;

   amc_seq #(.MAX_NODES(MAX_NODES), .CHAR_BITS(CHAR_BITS)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_if.data),
      .idle     (idle),
      .res_free (res_free),
      .res      (res),
      .rd_addr  (rd_addr),
      .rd_chr   (rd_chr),
      .rd_par   (rd_par),
      .rd_fail  (rd_fail),
      .rd_mark  (rd_mark),
      .wr_addr  (wr_addr),
      .wr_chr   (wr_chr),
      .wr_par   (wr_par),
      .wr_fail  (wr_fail),
      .wr_mark  (wr_mark),
      .we       (we)
   );

   amc_node_mem #(.MAX_NODES(MAX_NODES), .CHAR_BITS(CHAR_BITS)) u_mem (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_chr  (rd_chr),
      .rd_par  (rd_par),
      .rd_fail (rd_fail),
      .rd_mark (rd_mark),
      .wr_addr (wr_addr),
      .wr_chr  (wr_chr),
      .wr_par  (wr_par),
      .wr_fail (wr_fail),
      .wr_mark (wr_mark),
      .we      (we)
   );

   // Output register: holds a result beat until the sink takes it.
   assign res_free     = !rsp_valid_ff || rsp_if.ready;
   assign rsp_valid_in = res.valid || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         rsp_data_ff.status <= res.status;
         rsp_data_ff.hit    <= res.hit;
         rsp_data_ff.found  <= res.found;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;
endmodule
`default_nettype wire

@@ test/multi_pattern_string_matcher_checker.sv @@
// Checker that predicts and compares every result beat of the string matcher.
`timescale 1ns / 100ps
module multi_pattern_string_matcher_checker import amc_pkg::*; #(
   parameter int MAX_NODES = 256
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  wire req_payload_type req_data,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire rsp_payload_type rsp_data,
   output int                   fail_count,
   output int                   pending,
   output int                   hit_count,
   output int                   full_count
);

   // Shadow copy of the automaton.
   logic [15:0] edge_chr [MAX_NODES];
   int          parent   [MAX_NODES];
   int          fail_lnk [MAX_NODES];
   logic        word_end [MAX_NODES];
   int          node_cnt;
   int          ins_node;
   int          walk_node;
   logic        seen_word;
   logic        is_built;
   logic        ins_blocked;

   rsp_payload_type expected_rsp [$];

   function automatic void clear_trie();
      for (int i = 0; i < MAX_NODES; i++) begin
         edge_chr[i] = '0;
         parent[i]   = 0;
         fail_lnk[i] = 0;
         word_end[i] = 1'b0;
      end
      node_cnt    = 1;
      ins_node    = 0;
      walk_node   = 0;
      seen_word   = 1'b0;
      is_built    = 1'b0;
      ins_blocked = 1'b0;
   endfunction

   function automatic int child_node(int p, logic [15:0] c);
      for (int i = 1; i < node_cnt; i++)
         if (parent[i] == p && edge_chr[i] == c) return i;
      return 0;
   endfunction

   // Walk failure links until some node has a child on c, or the root.
   function automatic int follow_links(int s, logic [15:0] c);
      int guard;
      guard = 0;
      while (s != 0 && child_node(s, c) == 0 && guard < MAX_NODES) begin
         s = fail_lnk[s];
         guard++;
      end
      return s;
   endfunction

   // Breadth-first failure links; end marks are inherited along them.
   function automatic void build_links();
      int work [$];
      int u, f, g;
      fail_lnk[0] = 0;
      for (int i = 1; i < node_cnt; i++)
         if (parent[i] == 0) begin
            fail_lnk[i] = 0;
            work.push_back(i);
         end
      while (work.size() > 0) begin
         u = work.pop_front();
         for (int i = 1; i < node_cnt; i++) begin
            if (parent[i] != u || i == u) continue;
            f = follow_links(fail_lnk[u], edge_chr[i]);
            g = child_node(f, edge_chr[i]);
            fail_lnk[i] = (g != 0 && g != i) ? g : 0;
            if (word_end[fail_lnk[i]]) word_end[i] = 1'b1;
            work.push_back(i);
         end
      end
      is_built  = 1'b1;
      walk_node = 0;
      seen_word = 1'b0;
   endfunction

   function automatic rsp_payload_type predict_match(req_payload_type r);
      rsp_payload_type res;
      int nxt, s, g;
      res = '{status: STAT_OK, hit: 1'b0, found: 1'b0};
      case (req_code_type'(r.req_type))
         REQ_INSERT: begin
            is_built = 1'b0;
            if (r.first) begin
               ins_node    = 0;
               ins_blocked = 1'b0;
            end
            if (ins_blocked) begin
               res.status = STAT_FULL;
            end else begin
               nxt = child_node(ins_node, r.ch);
               if (nxt == 0) begin
                  if (node_cnt < MAX_NODES) begin
                     nxt = node_cnt++;
                     edge_chr[nxt] = r.ch;
                     parent[nxt]   = ins_node;
                     fail_lnk[nxt] = 0;
                     word_end[nxt] = 1'b0;
                  end else begin
                     ins_blocked = 1'b1;
                     res.status  = STAT_FULL;
                  end
               end
               if (!ins_blocked) begin
                  ins_node = nxt;
                  if (r.last) word_end[ins_node] = 1'b1;
               end
            end
         end
         REQ_BUILD: build_links();
         REQ_MATCH: begin
            if (r.first) begin
               walk_node = 0;
               seen_word = 1'b0;
            end
            if (!is_built) begin
               res.status = STAT_NOT_BUILT;
            end else begin
               s = follow_links(walk_node, r.ch);
               g = child_node(s, r.ch);
               if (g != 0) s = g;
               walk_node = s;
               res.hit = word_end[walk_node];
               if (res.hit) seen_word = 1'b1;
               res.found = seen_word;
            end
         end
         default: clear_trie();
      endcase
      return res;
   endfunction

   // Predict on each accepted request beat, compare on each result beat.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         clear_trie();
         expected_rsp.delete();
         fail_count = 0;
         hit_count  = 0;
         full_count = 0;
      end else begin
         if (req_valid && req_ready) expected_rsp.push_back(predict_match(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("result beat with no request outstanding");
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status === STAT_FULL) full_count++;
               if (rsp_data.hit === 1'b1) hit_count++;
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, rsp_data.hit);
                  fail_count++;
               end
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_rsp.size();
   end

endmodule

@@ test/multi_pattern_string_matcher_tb.sv @@
// Testbench top: stimulus, handshake pacing and verdict for the string matcher.
`timescale 1ns / 100ps
module multi_pattern_string_matcher_tb;
   import amc_pkg::*;

   localparam int IDLE_LIMIT = 2000000;

   logic clock;
   logic reset;
   int   sent_beats;
   int   idle_cycles;
   int   burst_left;
   int   stall_mode;
   int   fail_count, pending, hit_count, full_count;
   logic [15:0] alpha_base;

   amc_stream_if #(.payload_type(req_payload_type)) req_if ();
   amc_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   multi_pattern_string_matcher u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   multi_pattern_string_matcher_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_data   (req_if.data),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_data   (rsp_if.data),
      .fail_count (fail_count),
      .pending    (pending),
      .hit_count  (hit_count),
      .full_count (full_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver switches between no stalls, light stalls and heavy stalls.
   always @(negedge clock) begin
      if (reset) stall_mode = 0;
      else if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_if.ready <= 1'b1;
         1:       rsp_if.ready <= ($urandom_range(0, 9) > 2);
         default: rsp_if.ready <= ($urandom_range(0, 9) > 7);
      endcase
   end

   // Watchdog on cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Drive one request beat at the falling edge and hold it until accepted.
   task automatic send_beat(req_code_type kind, logic [15:0] c, logic fst, logic lst);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid = 1'b1;
      req_if.data  = '{req_type: kind, ch: c, first: fst, last: lst};
      do @(posedge clock); while (!req_if.ready);
      sent_beats++;
      @(negedge clock);
   endtask

   task automatic send_word(int len, logic mid_marks);
      for (int k = 0; k < len; k++)
         send_beat(REQ_INSERT, alpha_base + 16'($urandom_range(0, 3)), k == 0,
                   (k == len - 1) || (mid_marks && ($urandom_range(0, 3) == 0)));
   endtask

   task automatic send_text(int len);
      for (int k = 0; k < len; k++)
         send_beat(REQ_MATCH, alpha_base + 16'($urandom_range(0, 3)), k == 0,
                   1'($urandom_range(0, 1)));
   endtask

   initial begin
      req_payload_type noise;
      sent_beats   = 0;
      burst_left   = 0;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: match before build, extreme characters, overlapping words.
      send_beat(REQ_MATCH, 16'h0000, 1'b1, 1'b0);
      send_beat(REQ_MATCH, 16'hFFFF, 1'b0, 1'b0);
      send_beat(REQ_INSERT, 16'h0000, 1'b1, 1'b1);
      send_beat(REQ_INSERT, 16'hFFFF, 1'b1, 1'b0);
      send_beat(REQ_INSERT, 16'h0000, 1'b0, 1'b1);
      send_beat(REQ_INSERT, 16'h0000, 1'b1, 1'b0);
      send_beat(REQ_INSERT, 16'hFFFF, 1'b0, 1'b1);
      send_beat(REQ_BUILD, 16'h1234, 1'b0, 1'b0);
      send_beat(REQ_MATCH, 16'hFFFF, 1'b1, 1'b0);
      send_beat(REQ_MATCH, 16'h0000, 1'b0, 1'b0);
      send_beat(REQ_MATCH, 16'hFFFF, 1'b0, 1'b0);
      send_beat(REQ_MATCH, 16'h5555, 1'b0, 1'b0);
      send_beat(REQ_MATCH, 16'hAAAA, 1'b1, 1'b0);
      // An insert after the build drops the automaton back to unbuilt.
      send_beat(REQ_INSERT, 16'h5555, 1'b1, 1'b1);
      send_beat(REQ_MATCH, 16'h5555, 1'b0, 1'b0);
      send_beat(REQ_BUILD, 16'h0000, 1'b1, 1'b1);
      send_beat(REQ_MATCH, 16'h5555, 1'b0, 1'b1);
      send_beat(REQ_CLEAR, 16'hFFFF, 1'b1, 1'b1);
      send_beat(REQ_MATCH, 16'h5555, 1'b1, 1'b0);

      // Fill the node store with one-character words, then overflow it.
      for (int k = 1; k <= 258; k++)
         send_beat(REQ_INSERT, 16'(k * 37), 1'b1, 1'b1);
      send_beat(REQ_INSERT, 16'hBEEF, 1'b1, 1'b0);
      send_beat(REQ_INSERT, 16'h0025, 1'b0, 1'b1);
      send_beat(REQ_INSERT, 16'h0025, 1'b1, 1'b0);
      send_beat(REQ_MATCH, 16'h0025, 1'b1, 1'b0);
      send_beat(REQ_BUILD, 16'h0000, 1'b0, 1'b0);
      send_beat(REQ_MATCH, 16'h0025, 1'b1, 1'b0);
      send_beat(REQ_MATCH, 16'hBEEF, 1'b0, 1'b0);
      send_beat(REQ_CLEAR, 16'h0000, 1'b0, 1'b0);

      // Random phases: small pattern sets over a four-letter alphabet.
      while (sent_beats < 1600) begin
         alpha_base = 16'($urandom) & 16'hFFFC;
         if ($urandom_range(0, 3) != 0)
            send_beat(REQ_CLEAR, 16'($urandom), 1'($urandom), 1'($urandom));
         repeat ($urandom_range(1, 5))
            send_word($urandom_range(1, 4), 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 9) == 0) send_text($urandom_range(1, 3));
         send_beat(REQ_BUILD, 16'($urandom), 1'($urandom), 1'($urandom));
         repeat ($urandom_range(1, 4)) send_text($urandom_range(1, 12));
         // Occasional noise of any kind, including a continued word.
         if ($urandom_range(0, 4) == 0) begin
            noise = req_payload_type'(20'($urandom));
            send_beat(req_code_type'(noise.req_type), noise.ch, noise.first, noise.last);
         end
      end
      req_if.valid = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d request beats across directed, store-full and random trie phases.",
               sent_beats);
      $display("Saw %0d pattern hits and %0d store-full results.", hit_count, full_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/amc_pkg.sv
rtl/core/amc_stream_if.sv
rtl/core/amc_node_mem.sv
rtl/core/amc_seq.sv
rtl/core/multi_pattern_string_matcher.sv
test/multi_pattern_string_matcher_checker.sv
test/multi_pattern_string_matcher_tb.sv
